// ----- rtl/flvp_pkg.sv -----
// Package with the shared types, codes and constants of the FLV tag stream parser.
`timescale 1ns / 1ps

package flvp_pkg;

	localparam int OffsetWidthDefault = 32;

	// Parser phases.
	localparam logic [2:0] PH_SIG    = 3'd0;
	localparam logic [2:0] PH_HEAD   = 3'd1;
	localparam logic [2:0] PH_TAGHDR = 3'd2;
	localparam logic [2:0] PH_BODY   = 3'd3;
	localparam logic [2:0] PH_TRAIL  = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SIG   = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
	localparam logic [1:0] ST_BAD_TRAIL = 2'd3;

	// Tag kind codes and the type bytes that map to them.
	localparam logic [1:0] KIND_AUDIO = 2'd0;
	localparam logic [1:0] KIND_VIDEO = 2'd1;
	localparam logic [1:0] KIND_META  = 2'd2;
	localparam logic [7:0] TYPE_AUDIO = 8'h08;
	localparam logic [7:0] TYPE_VIDEO = 8'h09;
	localparam logic [7:0] TYPE_META  = 8'h12;

	// Header layout.
	localparam logic [23:0] FILE_HDR_LAST  = 24'd12;
	localparam logic [23:0] TAG_HDR_LAST   = 24'd10;
	localparam logic [23:0] LEN_LAST_BYTE  = 24'd3;
	localparam logic [23:0] TRAIL_LAST     = 24'd3;
	localparam logic [23:0] SIG_LAST       = 24'd2;
	localparam logic [23:0] HEAD_START     = 24'd3;
	localparam logic [31:0] TAG_HDR_BYTES  = 32'd11;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  tag_kind;
		logic [23:0] body_length;
		logic [31:0] tag_offset;
	} res_t;

	// Expected signature bytes 'F', 'L', 'V'.
	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h46;
			2'd1: b = 8'h4C;
			2'd2: b = 8'h56;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/flv_tag_stream_parser.sv -----
// Top level of the FLV tag stream parser.
`timescale 1ns / 1ps

// Streams an FLV container one byte per beat, checks the 'FLV' signature, skips the
// 13-byte file header and then walks the tags, emitting one result beat per tag on its
// last trailing-size byte (status ok or trailing size mismatch), or at once on a bad
// signature byte or bad tag type. After any error beat the parser drops all further
// input bytes without a result until reset. Each byte is held in an input register
// and the state update for it is one short pass of logic, so one byte is taken
// every cycle; throughput is set only by the two-entry result buffer, which lets input
// continue while a result waits and stalls input only when two results are unread.
// A result beat is registered in the result buffer. Offsets count from
// file start on OFFSET_WIDTH bits, saturate at the maximum and are reported on 32 bits,
// saturating there as well.

module flv_tag_stream_parser #(
	parameter int OFFSET_WIDTH = flvp_pkg::OffsetWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [1:0]  tag_kind,
	output logic [23:0] body_length,
	output logic [31:0] tag_offset
);

	logic           res_full;
	logic           res_valid;
	flvp_pkg::res_t res;
	flvp_pkg::res_t res_out;

	// Parsing state machine behind the input register.
	flvp_parse_core #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_value(byte_value),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res_full  (res_full),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register plus skid slot decouples the output handshake.
	flvp_result_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.din      (res),
		.full     (res_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dout     (res_out)
	);

	assign status      = res_out.status;
	assign tag_kind    = res_out.tag_kind;
	assign body_length = res_out.body_length;
	assign tag_offset  = res_out.tag_offset;

endmodule

// ----- rtl/flvp_parse_core.sv -----
// Input register and per-byte parsing state machine of the FLV tag stream parser.
`timescale 1ns / 1ps

module flvp_parse_core #(
	parameter int OFFSET_WIDTH = flvp_pkg::OffsetWidthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_value,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                res_full,
	output logic                res_valid,
	output flvp_pkg::res_t      res
);

	logic                    vld_s1;
	logic [7:0]              byte_s1;
	logic                    step;

	logic [2:0]              phase_q, phase_d;
	logic [23:0]             cnt_q, cnt_d;
	logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
	logic [OFFSET_WIDTH-1:0] start_q, start_d;
	logic [23:0]             len_q, len_d;
	logic [1:0]              kind_q, kind_d;
	logic [31:0]             acc_q, acc_d;
	logic                    halted_q, halted_d;

	logic [31:0]             pos_clip;
	logic [31:0]             start_clip;

	assign step     = vld_s1 && !res_full;
	assign in_ready = !vld_s1 || !res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
		end
	end

	// Offsets are reported on 32 bits and saturate there.
	generate
		if (OFFSET_WIDTH > 32) begin : g_clip
			assign pos_clip   = (|pos_q[OFFSET_WIDTH-1:32]) ? '1 : pos_q[31:0];
			assign start_clip = (|start_q[OFFSET_WIDTH-1:32]) ? '1 : start_q[31:0];
		end else begin : g_ext
			assign pos_clip   = 32'(pos_q);
			assign start_clip = 32'(start_q);
		end
	endgenerate

	always_comb begin
		logic [31:0] acc_new;
		logic [24:0] cnt_inc;
		acc_new   = {acc_q[23:0], byte_s1};
		cnt_inc   = {1'b0, cnt_q} + 25'd1;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		start_d   = start_q;
		len_d     = len_q;
		kind_d    = kind_q;
		acc_d     = acc_q;
		halted_d  = halted_q;
		res_valid = 1'b0;
		res       = '0;
		if (step && !halted_q) begin
			if (pos_q != '1) begin
				pos_d = pos_q + 1'b1;
			end
			case (phase_q)
				flvp_pkg::PH_SIG: begin
					if (byte_s1 != flvp_pkg::sig_byte(cnt_q[1:0])) begin
						res_valid  = 1'b1;
						res.status = flvp_pkg::ST_BAD_SIG;
						halted_d   = 1'b1;
					end else if (cnt_q == flvp_pkg::SIG_LAST) begin
						phase_d = flvp_pkg::PH_HEAD;
						cnt_d   = flvp_pkg::HEAD_START;
					end else begin
						cnt_d = cnt_inc[23:0];
					end
				end
				flvp_pkg::PH_HEAD: begin
					if (cnt_q == flvp_pkg::FILE_HDR_LAST) begin
						phase_d = flvp_pkg::PH_TAGHDR;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_inc[23:0];
					end
				end
				flvp_pkg::PH_TAGHDR: begin
					if (cnt_q == '0) begin
						start_d = pos_q;
						len_d   = '0;
						cnt_d   = cnt_inc[23:0];
						case (byte_s1)
							flvp_pkg::TYPE_AUDIO: kind_d = flvp_pkg::KIND_AUDIO;
							flvp_pkg::TYPE_VIDEO: kind_d = flvp_pkg::KIND_VIDEO;
							flvp_pkg::TYPE_META:  kind_d = flvp_pkg::KIND_META;
							default: begin
								res_valid      = 1'b1;
								res.status     = flvp_pkg::ST_BAD_TYPE;
								res.tag_offset = pos_clip;
								halted_d       = 1'b1;
							end
						endcase
					end else if (cnt_q == flvp_pkg::TAG_HDR_LAST) begin
						cnt_d   = '0;
						acc_d   = '0;
						phase_d = (len_q != '0) ? flvp_pkg::PH_BODY : flvp_pkg::PH_TRAIL;
					end else begin
						if (cnt_q <= flvp_pkg::LEN_LAST_BYTE) begin
							len_d = {len_q[15:0], byte_s1};
						end
						cnt_d = cnt_inc[23:0];
					end
				end
				flvp_pkg::PH_BODY: begin
					if (cnt_inc >= {1'b0, len_q}) begin
						cnt_d   = '0;
						acc_d   = '0;
						phase_d = flvp_pkg::PH_TRAIL;
					end else begin
						cnt_d = cnt_inc[23:0];
					end
				end
				default: begin
					if (cnt_q == flvp_pkg::TRAIL_LAST) begin
						res_valid       = 1'b1;
						res.tag_kind    = kind_q;
						res.body_length = len_q;
						res.tag_offset  = start_clip;
						if (acc_new == {8'd0, len_q} + flvp_pkg::TAG_HDR_BYTES) begin
							res.status = flvp_pkg::ST_OK;
						end else begin
							res.status = flvp_pkg::ST_BAD_TRAIL;
							halted_d   = 1'b1;
						end
						phase_d = flvp_pkg::PH_TAGHDR;
						cnt_d   = '0;
						acc_d   = '0;
					end else begin
						acc_d = acc_new;
						cnt_d = cnt_inc[23:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= flvp_pkg::PH_SIG;
			cnt_q    <= '0;
			pos_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
			kind_q   <= '0;
			acc_q    <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
			len_q    <= len_d;
			kind_q   <= kind_d;
			acc_q    <= acc_d;
			halted_q <= halted_d;
		end
	end

endmodule

// ----- rtl/flvp_result_fifo.sv -----
// Two-entry result register with skid slot for the FLV tag stream parser.
`timescale 1ns / 1ps

module flvp_result_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  flvp_pkg::res_t din,
	output logic           full,
	output logic           out_valid,
	input  logic           out_ready,
	output flvp_pkg::res_t dout
);

	flvp_pkg::res_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- sim/flv_tag_stream_parser_tb.sv -----
// Self-checking testbench for the FLV tag stream parser: random FLV streams, predicted tag results.
`timescale 1ns / 1ps

module flv_tag_stream_parser_tb;

	localparam int FILE_HDR_BYTES = 13;
	localparam int TAG_HDR_BYTES_N = 11;
	localparam int TRAILER_BYTES = 4;
	localparam int IDLE_PCT = 34;
	localparam int RANDOM_ITEMS = 1000;
	localparam logic [7:0] FLV_SIG [3] = '{8'h46, 8'h4C, 8'h56};

	// Predicts the per-tag results of the parser and compares them with what it emits.
	class tag_scoreboard;
		logic [2:0] phase;
		logic [24:0] phase_count;
		logic [31:0] byte_pos;
		logic [31:0] tag_start;
		logic [23:0] held_length;
		logic [1:0] held_kind;
		logic [31:0] trailer_accum;
		bit halted;
		flvp_pkg::res_t expected_tags[$];
		int fail_count;

		function new();
			phase = flvp_pkg::PH_SIG;
			phase_count = '0;
			byte_pos = '0;
			tag_start = '0;
			held_length = '0;
			held_kind = '0;
			trailer_accum = '0;
			halted = 1'b0;
			fail_count = 0;
		endfunction

		function int pending();
			return expected_tags.size();
		endfunction

		function void push_result(input logic [1:0] st, input logic [1:0] kind,
				input logic [23:0] len, input logic [31:0] off);
			flvp_pkg::res_t r;
			r.status = st;
			r.tag_kind = kind;
			r.body_length = len;
			r.tag_offset = off;
			expected_tags.push_back(r);
		endfunction

		// Runs one accepted byte through the parsing state.
		function void note_byte(input logic [7:0] b);
			logic [31:0] here;
			logic ok;
			here = byte_pos;
			if (halted)
				return;
			// The position saturates at its maximum.
			if (byte_pos != 32'hFFFF_FFFF)
				byte_pos = byte_pos + 32'd1;
			case (phase)
				flvp_pkg::PH_SIG: begin
					if (b != FLV_SIG[phase_count[1:0]]) begin
						push_result(flvp_pkg::ST_BAD_SIG, 2'd0, 24'd0, 32'd0);
						halted = 1'b1;
						return;
					end
					phase_count = phase_count + 25'd1;
					if (phase_count >= 25'd3)
						phase = flvp_pkg::PH_HEAD;
				end
				flvp_pkg::PH_HEAD: begin
					phase_count = phase_count + 25'd1;
					if (phase_count >= 25'(FILE_HDR_BYTES)) begin
						phase = flvp_pkg::PH_TAGHDR;
						phase_count = '0;
					end
				end
				flvp_pkg::PH_TAGHDR: begin
					if (phase_count == 25'd0) begin
						tag_start = here;
						if (b == flvp_pkg::TYPE_AUDIO)
							held_kind = flvp_pkg::KIND_AUDIO;
						else if (b == flvp_pkg::TYPE_VIDEO)
							held_kind = flvp_pkg::KIND_VIDEO;
						else if (b == flvp_pkg::TYPE_META)
							held_kind = flvp_pkg::KIND_META;
						else begin
							push_result(flvp_pkg::ST_BAD_TYPE, 2'd0, 24'd0, here);
							halted = 1'b1;
							return;
						end
						held_length = '0;
					end else if (phase_count <= 25'd3) begin
						held_length = {held_length[15:0], b};
					end
					phase_count = phase_count + 25'd1;
					if (phase_count >= 25'(TAG_HDR_BYTES_N)) begin
						phase_count = '0;
						trailer_accum = '0;
						phase = (held_length != 24'd0) ? flvp_pkg::PH_BODY : flvp_pkg::PH_TRAIL;
					end
				end
				flvp_pkg::PH_BODY: begin
					phase_count = phase_count + 25'd1;
					if (phase_count >= {1'b0, held_length}) begin
						phase_count = '0;
						trailer_accum = '0;
						phase = flvp_pkg::PH_TRAIL;
					end
				end
				default: begin
					trailer_accum = {trailer_accum[23:0], b};
					phase_count = phase_count + 25'd1;
					if (phase_count >= 25'(TRAILER_BYTES)) begin
						ok = (trailer_accum == {8'd0, held_length} + 32'd11);
						push_result(ok ? flvp_pkg::ST_OK : flvp_pkg::ST_BAD_TRAIL, held_kind,
							held_length, tag_start);
						if (!ok)
							halted = 1'b1;
						phase = flvp_pkg::PH_TAGHDR;
						phase_count = '0;
						trailer_accum = '0;
					end
				end
			endcase
		endfunction

		function void check_result(input flvp_pkg::res_t got);
			flvp_pkg::res_t want;
			if (expected_tags.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result beat: status %0d kind %0d len %0d offset %0d",
						got.status, got.tag_kind, got.body_length, got.tag_offset);
				return;
			end
			want = expected_tags.pop_front();
			if (got !== want) begin
				fail_count++;
				if (fail_count <= 10)
					$display({"result mismatch: status exp %0d got %0d, kind exp %0d got %0d, ",
						"len exp %0d got %0d, offset exp %0d got %0d"},
						want.status, got.status, want.tag_kind, got.tag_kind,
						want.body_length, got.body_length, want.tag_offset, got.tag_offset);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] byte_value;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [1:0] tag_kind;
	logic [23:0] body_length;
	logic [31:0] tag_offset;

	tag_scoreboard tag_sb;
	int bytes_sent;
	bit tx_gaps;
	bit rx_gaps;
	int hold_req;

	flv_tag_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.tag_kind(tag_kind),
		.body_length(body_length),
		.tag_offset(tag_offset)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Beats are sampled at the edge; drivers change inputs only through nonblocking writes.
	always @(posedge clk) begin
		flvp_pkg::res_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				tag_sb.note_byte(byte_value);
			if (out_valid && out_ready) begin
				got.status = status;
				got.tag_kind = tag_kind;
				got.body_length = body_length;
				got.tag_offset = tag_offset;
				tag_sb.check_result(got);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when the sender asks for one.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			out_ready <= 1'b0;
			hold_req = hold_req - 1;
		end else if (rx_gaps && $urandom_range(99) < IDLE_PCT)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	task automatic send_byte(input logic [7:0] b);
		if (tx_gaps) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		byte_value <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_tag(input logic [7:0] type_byte, input logic [23:0] len,
			input logic [31:0] trailer);
		send_byte(type_byte);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		repeat (TAG_HDR_BYTES_N - 4)
			send_byte(8'($urandom));
		for (int i = 0; i < int'(len); i++)
			send_byte(8'($urandom));
		send_byte(trailer[31:24]);
		send_byte(trailer[23:16]);
		send_byte(trailer[15:8]);
		send_byte(trailer[7:0]);
	endtask

	function automatic logic [7:0] kind_type_byte(input int unsigned k);
		case (k)
			0: return flvp_pkg::TYPE_AUDIO;
			1: return flvp_pkg::TYPE_VIDEO;
			default: return flvp_pkg::TYPE_META;
		endcase
	endfunction

	// Mostly short bodies so that many tags go by; an occasional longer one.
	function automatic logic [23:0] pick_len();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 24'($urandom_range(8));
		else if (roll < 90)
			return 24'($urandom_range(40, 9));
		return 24'($urandom_range(300, 41));
	endfunction

	task automatic send_good_tag(input int unsigned k, input logic [23:0] len);
		send_tag(kind_type_byte(k), len, {8'd0, len} + 32'd11);
	endtask

	task automatic send_random_tag();
		send_good_tag($urandom_range(2), pick_len());
	endtask

	// Lets the last accepted byte reach the prediction before it waits for the results.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tag_sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_noise(input int count);
		repeat (count)
			send_byte(8'($urandom));
	endtask

	initial begin
		int unsigned prefix;
		logic [7:0] bad;
		logic [23:0] len;
		logic [31:0] trailer;

		tag_sb = new();
		in_valid = 1'b0;
		byte_value = 8'h00;
		out_ready = 1'b0;
		arst_n = 1'b0;
		bytes_sent = 0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_req = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Now and then the whole run is a broken signature: the parser halts for good.
		if ($urandom_range(7) == 0) begin
			prefix = $urandom_range(2);
			for (int i = 0; i < int'(prefix); i++)
				send_byte(FLV_SIG[i]);
			bad = 8'($urandom);
			while (bad == FLV_SIG[prefix])
				bad = 8'($urandom);
			send_byte(bad);
			send_noise(RANDOM_ITEMS);
		end else begin
			// Directed: skipped header bytes at both extremes, each kind, empty body.
			for (int i = 0; i < 3; i++)
				send_byte(FLV_SIG[i]);
			send_byte(8'h00);
			send_byte(8'hFF);
			send_byte(8'h05);
			send_byte(8'h00);
			send_byte(8'h00);
			send_byte(8'h00);
			send_byte(8'h09);
			send_byte(8'hFF);
			send_byte(8'hAA);
			send_byte(8'h55);
			send_good_tag(0, 24'd0);
			send_good_tag(1, 24'd1);
			send_good_tag(2, 24'h000100);
			send_good_tag(0, 24'd3);

			// The sender waits until every expected result is out.
			drain_results();

			// No idling on either side for a while.
			tx_gaps = 1'b0;
			rx_gaps = 1'b0;
			repeat (8)
				send_random_tag();

			// Long receiver hold-off against short back-to-back tags fills the result buffer.
			hold_req = 300;
			repeat (12)
				send_good_tag($urandom_range(2), 24'($urandom_range(2)));
			tx_gaps = 1'b1;
			rx_gaps = 1'b1;

			while (bytes_sent < RANDOM_ITEMS)
				send_random_tag();

			// The run ends on one error of the tag walk; the following bytes are ignored.
			if ($urandom_range(1) == 0) begin
				bad = 8'($urandom);
				while (bad == flvp_pkg::TYPE_AUDIO || bad == flvp_pkg::TYPE_VIDEO ||
						bad == flvp_pkg::TYPE_META)
					bad = 8'($urandom);
				send_byte(bad);
			end else begin
				len = pick_len();
				case ($urandom_range(2))
					0: trailer = {8'h01, len} + 32'd11;
					1: trailer = {8'd0, len} + 32'd10;
					default: trailer = $urandom;
				endcase
				send_tag(kind_type_byte($urandom_range(2)), len, trailer);
			end
			send_noise(40);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (tag_sb.fail_count == 0 && tag_sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
